[src/assert_macros.svh]
// assertion macros shared by the rtl that checks itself
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition a in one cycle implies b in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed: same-cycle implication");

// condition a in one cycle implies b in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed: next-cycle implication");

`endif

[src/spq_pkg.sv]
// types and codes for the stable sorted priority queue
// no dependencies
`timescale 1ns / 1ps

package spq_pkg;

	localparam int PRIO_W = 8;
	localparam int TAG_W  = 32;

	// operation codes
	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_REMOVE = 1'b1;

	// result status codes
	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_EMPTY = 2'd2;

	// one stored entry
	typedef struct packed {
		logic [PRIO_W-1:0] prio;
		logic [TAG_W-1:0]  tag;
	} entry_t;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic   ins;
		logic   rem;
		entry_t new_entry;
	} cell_ctl_t;

endpackage

[src/spq_cell.sv]
// one slot of the sorted queue: holds an entry, shifts on insert or remove
// depends on spq_pkg
`timescale 1ns / 1ps

module spq_cell
	import spq_pkg::*;
(
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  logic      occupied,
	input  logic      left_keep,
	input  entry_t    left_entry,
	input  entry_t    right_entry,
	output logic      keep,
	output entry_t    entry
);

	entry_t entry_q;

	// an occupied entry stays put on insert when it ranks equal to or above the new word
	assign keep  = occupied && (entry_q.prio >= ctl.new_entry.prio);
	assign entry = entry_q;

	// insert: take the new word at the boundary, the left neighbor behind it
	// remove: take the right neighbor
	always_ff @(posedge clk) begin
		if (ctl.ins && !keep) begin
			entry_q <= left_keep ? ctl.new_entry : left_entry;
		end else if (ctl.rem) begin
			entry_q <= right_entry;
		end
	end

endmodule

[src/stable_sorted_priority_queue.sv]
// stable sorted priority queue: a row of DEPTH cells, head at cell zero
// result: strobed on done in the cycle after the one in which start is accepted
// throughput: one operation per cycle; every cell compares and shifts at once
// busy is always low; the receiver cannot stall and needs none
// reset: arst_n clears the fill count and the result strobe; slots are not cleared
`timescale 1ns / 1ps

module stable_sorted_priority_queue
	import spq_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              func,
	input  logic [PRIO_W-1:0] prio_in,
	input  logic [TAG_W-1:0]  tag_in,
	output logic              done,
	output logic [1:0]        status,
	output logic [PRIO_W-1:0] prio_out,
	output logic [TAG_W-1:0]  tag_out,
	output logic              now_empty,
	output logic              now_full
);

`include "assert_macros.svh"

	localparam int FILL_W = $clog2(DEPTH + 1);

	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] fill_next;
	logic              accept;
	logic              is_empty;
	logic              is_full;
	cell_ctl_t         ctl;
	entry_t            cell_entry [DEPTH];
	logic [DEPTH-1:0]  cell_keep;

	logic              done_q;
	logic [1:0]        status_q;
	logic [PRIO_W-1:0] prio_out_q;
	logic [TAG_W-1:0]  tag_out_q;
	logic              now_empty_q;
	logic              now_full_q;

	assign busy     = 1'b0;
	assign accept   = start && !busy;
	assign is_empty = (fill_q == '0);
	assign is_full  = (fill_q == FILL_W'(DEPTH));

	// command to the cell row
	always_comb begin
		ctl.ins       = accept && (func == FUNC_INSERT) && !is_full;
		ctl.rem       = accept && (func == FUNC_REMOVE) && !is_empty;
		ctl.new_entry = '{prio: prio_in, tag: tag_in};
	end

	// row of cells
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic   occ;
		logic   lkeep;
		entry_t lentry;
		entry_t rentry;

		assign occ = (FILL_W'(i) < fill_q);
		if (i == 0) begin : g_head
			assign lkeep  = 1'b1;
			assign lentry = ctl.new_entry;
		end else begin : g_body
			assign lkeep  = cell_keep[i-1];
			assign lentry = cell_entry[i-1];
		end
		if (i == DEPTH - 1) begin : g_tail
			assign rentry = cell_entry[i];
		end else begin : g_inner
			assign rentry = cell_entry[i+1];
		end

		spq_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.occupied   (occ),
			.left_keep  (lkeep),
			.left_entry (lentry),
			.right_entry(rentry),
			.keep       (cell_keep[i]),
			.entry      (cell_entry[i])
		);
	end

	// next fill count
	always_comb begin
		priority if (ctl.ins) begin
			fill_next = fill_q + FILL_W'(1);
		end else if (ctl.rem) begin
			fill_next = fill_q - FILL_W'(1);
		end else begin
			fill_next = fill_q;
		end
	end

	// fill count and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			done_q <= 1'b0;
		end else begin
			fill_q <= fill_next;
			done_q <= accept;
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q    <= STATUS_OK;
			prio_out_q  <= '0;
			tag_out_q   <= '0;
			now_empty_q <= (fill_next == '0);
			now_full_q  <= (fill_next == FILL_W'(DEPTH));
			if (func == FUNC_INSERT) begin
				if (is_full) begin
					status_q <= STATUS_FULL;
				end
			end else if (is_empty) begin
				status_q <= STATUS_EMPTY;
			end else begin
				prio_out_q <= cell_entry[0].prio;
				tag_out_q  <= cell_entry[0].tag;
			end
		end
	end

	assign done      = done_q;
	assign status    = status_q;
	assign prio_out  = prio_out_q;
	assign tag_out   = tag_out_q;
	assign now_empty = now_empty_q;
	assign now_full  = now_full_q;

	// checks
	`ASSERT_IMPLIES(a_fill_range, clk, arst_n, 1'b1, fill_q <= FILL_W'(DEPTH))
	`ASSERT_NEXT(a_done_follows, clk, arst_n, accept, done)
	`ASSERT_IMPLIES(a_drop_full, clk, arst_n, done && (status == STATUS_FULL), now_full)
	`ASSERT_IMPLIES(a_empty_zero, clk, arst_n, done && (status == STATUS_EMPTY), now_empty && (prio_out == '0) && (tag_out == '0))
	`ASSERT_IMPLIES(a_head_sorted, clk, arst_n, fill_q >= FILL_W'(2), cell_entry[0].prio >= cell_entry[1].prio)

endmodule
